>>> src/scrf_pkg.sv
// ----------------------------------------------------------------------------
// Shifting cell register fabric package
// Geometry, command codes, controller states and shared types.
// ----------------------------------------------------------------------------
package scrf_pkg;

  localparam int COLUMNS    = 4;
  localparam int SUPERLANES = 2;
  localparam int STREAMS    = 4;
  localparam int LANES      = 4;
  localparam int PRODUCERS  = 2;
  localparam int CONSUMERS  = 2;

  // One row is every cell of one column; a tick moves whole rows between columns.
  localparam int ROWS   = SUPERLANES * STREAMS * LANES;
  localparam int NCELLS = COLUMNS * ROWS;
  localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int PROD_W = (PRODUCERS > 1) ? $clog2(PRODUCERS) : 1;
  localparam int CONS_W = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
  localparam int CNT_W  = $clog2(PRODUCERS + 3);

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_INJECT  = 3'd1,
    CMD_CONSUME = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctrl_state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load;   // an input transfer happens; execute it and capture the result
  } dp_cmd_t;

endpackage

>>> src/scrf_ctrl.sv
// ----------------------------------------------------------------------------
// Shifting cell register fabric controller
// Tracks the result register and derives the handshake on both channels.
// ----------------------------------------------------------------------------
module scrf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output scrf_pkg::dp_cmd_t dp_cmd_o
);

  scrf_pkg::ctrl_state_e state_q, state_d;
  logic load;

  // A new item may enter whenever the held result leaves in the same cycle.
  assign load = in_valid_i && !(state_q == scrf_pkg::ST_FULL && out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scrf_pkg::ST_EMPTY: begin
        if (load) state_d = scrf_pkg::ST_FULL;
      end
      scrf_pkg::ST_FULL: begin
        if (!out_stall_i && !load) state_d = scrf_pkg::ST_EMPTY;
      end
      default: state_d = scrf_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q == scrf_pkg::ST_FULL) && out_stall_i;
    out_valid_o   = (state_q == scrf_pkg::ST_FULL);
    dp_cmd_o.load = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scrf_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/scrf_datapath.sv
// ----------------------------------------------------------------------------
// Shifting cell register fabric datapath
// Cell array, pending event stores, flags, tick counter and result register.
// ----------------------------------------------------------------------------
module scrf_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scrf_pkg::dp_cmd_t dp_cmd_i,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic [2:0]        cmd_i,
  input  logic [7:0]        port_index_i,
  input  logic [7:0]        column_i,
  input  logic [7:0]        superlane_i,
  input  logic [7:0]        stream_i,
  input  logic [7:0]        lane_i,
  input  logic [7:0]        data_i,
  output logic              accepted_o,
  output logic              cell_valid_o,
  output logic [7:0]        cell_data_o,
  output logic              collision_o,
  output logic              invalid_consume_o,
  output logic [31:0]       tick_count_o
);

  localparam int NC = scrf_pkg::NCELLS;
  localparam int NP = scrf_pkg::PRODUCERS;
  localparam int NK = scrf_pkg::CONSUMERS;
  localparam int CW = scrf_pkg::CELL_W;

  logic        flow_q;
  logic [7:0]  cell_byte_q [NC];
  logic [NC-1:0] cell_val_q;
  logic [NP-1:0] inj_flag_q [NC];
  logic [7:0]  inj_byte_q [NC][NP];
  logic [NK-1:0] cons_flag_q [NC];
  logic [NC-1:0] wr_flag_q;
  logic [7:0]  wr_byte_q [NC];
  logic        coll_q, bad_q, open_q;
  logic [31:0] ticks_q;

  logic        res_acc_q, res_val_q, res_coll_q, res_bad_q;
  logic [7:0]  res_data_q;

  // Address decode.
  logic          addr_ok, inj_ok, cons_ok;
  logic [31:0]   lin;
  logic [CW-1:0] cell_sel;
  logic [scrf_pkg::PROD_W-1:0] pidx;
  logic [scrf_pkg::CONS_W-1:0] kidx;

  always_comb begin
    addr_ok = (32'(column_i) < scrf_pkg::COLUMNS) && (32'(superlane_i) < scrf_pkg::SUPERLANES)
           && (32'(stream_i) < scrf_pkg::STREAMS) && (32'(lane_i) < scrf_pkg::LANES);
    lin = ((32'(column_i) * scrf_pkg::SUPERLANES + 32'(superlane_i)) * scrf_pkg::STREAMS
          + 32'(stream_i)) * scrf_pkg::LANES + 32'(lane_i);
    cell_sel = addr_ok ? lin[CW-1:0] : '0;
    inj_ok   = addr_ok && (32'(port_index_i) < NP);
    cons_ok  = addr_ok && (32'(port_index_i) < NK);
    pidx     = port_index_i[scrf_pkg::PROD_W-1:0];
    kidx     = port_index_i[scrf_pkg::CONS_W-1:0];
  end

  // Tick evaluation: every cell in parallel.
  logic [7:0]    nxt_byte [NC];
  logic [NC-1:0] nxt_val, coll_v, bad_v;

  for (genvar t = 0; t < NC; t++) begin : g_cell
    localparam bit HAS_E = (t >= scrf_pkg::ROWS);
    localparam bit HAS_W = (t + scrf_pkg::ROWS < NC);
    localparam int SRC_E = HAS_E ? t - scrf_pkg::ROWS : t;
    localparam int SRC_W = HAS_W ? t + scrf_pkg::ROWS : t;
    logic [7:0] ud;
    logic       uv;
    logic [scrf_pkg::CNT_W-1:0] cnt;

    always_comb begin
      ud = 8'd0;
      uv = 1'b0;
      if (!flow_q && HAS_E) begin
        ud = cell_byte_q[SRC_E];
        uv = cell_val_q[SRC_E] && !(|cons_flag_q[SRC_E]);
      end else if (flow_q && HAS_W) begin
        ud = cell_byte_q[SRC_W];
        uv = cell_val_q[SRC_W] && !(|cons_flag_q[SRC_W]);
      end
      nxt_byte[t] = ud;
      nxt_val[t]  = uv;
      cnt = {{(scrf_pkg::CNT_W-1){1'b0}}, uv};
      if (wr_flag_q[t]) begin
        nxt_byte[t] = wr_byte_q[t];
        nxt_val[t]  = 1'b1;
        cnt = cnt + 1'b1;
      end
      // Walk producers from the highest so that the lowest one wins.
      for (int p = NP - 1; p >= 0; p--) begin
        if (inj_flag_q[t][p]) begin
          nxt_byte[t] = inj_byte_q[t][p];
          nxt_val[t]  = 1'b1;
          cnt = cnt + 1'b1;
        end
      end
      coll_v[t] = (cnt >= scrf_pkg::CNT_W'(2));
      bad_v[t]  = (|cons_flag_q[t]) && !cell_val_q[t];
    end
  end

  // Flags as seen by a batch event: a closed batch starts from clear flags.
  logic coll_base, bad_base, other_inj;
  logic acc_n, val_n, coll_n, bad_n;
  logic [7:0] data_n;

  always_comb begin
    coll_base = open_q ? coll_q : 1'b0;
    bad_base  = open_q ? bad_q : 1'b0;
    other_inj = 1'b0;
    for (int p = 0; p < NP; p++) begin
      if (p[scrf_pkg::PROD_W-1:0] != pidx && inj_flag_q[cell_sel][p]) other_inj = 1'b1;
    end
    acc_n  = 1'b0;
    val_n  = 1'b0;
    data_n = 8'd0;
    coll_n = coll_q;
    bad_n  = bad_q;
    case (cmd_i)
      scrf_pkg::CMD_TICK: begin
        acc_n  = 1'b1;
        coll_n = |coll_v;
        bad_n  = |bad_v;
      end
      scrf_pkg::CMD_INJECT: begin
        if (inj_ok) begin
          acc_n  = 1'b1;
          coll_n = coll_base || other_inj || wr_flag_q[cell_sel];
          bad_n  = bad_base;
        end
      end
      scrf_pkg::CMD_CONSUME: begin
        if (cons_ok) begin
          acc_n  = 1'b1;
          coll_n = coll_base;
          bad_n  = bad_base || !cell_val_q[cell_sel];
        end
      end
      scrf_pkg::CMD_WRITE: begin
        if (addr_ok) begin
          acc_n  = 1'b1;
          val_n  = 1'b1;
          data_n = data_i;
          coll_n = coll_base || (|inj_flag_q[cell_sel]);
          bad_n  = bad_base;
        end
      end
      scrf_pkg::CMD_READ: begin
        if (addr_ok) begin
          acc_n  = 1'b1;
          val_n  = cell_val_q[cell_sel];
          data_n = cell_byte_q[cell_sel];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q     <= 1'b0;
      cell_val_q <= '0;
      wr_flag_q  <= '0;
      coll_q     <= 1'b0;
      bad_q      <= 1'b0;
      open_q     <= 1'b0;
      ticks_q    <= 32'd0;
      res_acc_q  <= 1'b0;
      res_val_q  <= 1'b0;
      res_coll_q <= 1'b0;
      res_bad_q  <= 1'b0;
      res_data_q <= 8'd0;
      for (int t = 0; t < NC; t++) begin
        cell_byte_q[t] <= 8'd0;
        inj_flag_q[t]  <= '0;
        cons_flag_q[t] <= '0;
      end
    end else begin
      if (cfg_we_i) flow_q <= cfg_data_i;
      if (dp_cmd_i.load) begin
        res_acc_q  <= acc_n;
        res_val_q  <= val_n;
        res_data_q <= data_n;
        res_coll_q <= coll_n;
        res_bad_q  <= bad_n;
        coll_q     <= coll_n;
        bad_q      <= bad_n;
        case (cmd_i)
          scrf_pkg::CMD_TICK: begin
            ticks_q    <= ticks_q + 32'd1;
            open_q     <= 1'b0;
            cell_val_q <= nxt_val;
            wr_flag_q  <= '0;
            for (int t = 0; t < NC; t++) begin
              cell_byte_q[t] <= nxt_byte[t];
              inj_flag_q[t]  <= '0;
              cons_flag_q[t] <= '0;
            end
          end
          scrf_pkg::CMD_INJECT: begin
            if (inj_ok) begin
              open_q <= 1'b1;
              inj_flag_q[cell_sel][pidx] <= 1'b1;
              inj_byte_q[cell_sel][pidx] <= data_i;
            end
          end
          scrf_pkg::CMD_CONSUME: begin
            if (cons_ok) begin
              open_q <= 1'b1;
              cons_flag_q[cell_sel][kidx] <= 1'b1;
            end
          end
          scrf_pkg::CMD_WRITE: begin
            if (addr_ok) begin
              open_q              <= 1'b1;
              wr_flag_q[cell_sel] <= 1'b1;
              wr_byte_q[cell_sel] <= data_i;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign accepted_o        = res_acc_q;
  assign cell_valid_o      = res_val_q;
  assign cell_data_o       = res_data_q;
  assign collision_o       = res_coll_q;
  assign invalid_consume_o = res_bad_q;
  // The count only moves on a tick, whose own result shows the new value.
  assign tick_count_o      = ticks_q;

endmodule

>>> src/shifting_cell_register_fabric.sv
// ----------------------------------------------------------------------------
// Shifting cell register fabric
// Grid of byte cells that shift one column per tick, with pending events.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries one command (tick, inject, consume, write or
// read) with a cell address, a port number and a data byte. Every input
// transfer produces exactly one output transfer with the accepted bit, the
// cell valid bit and byte, both flags and the tick count.
// The result is registered: the result of an item accepted at an edge is valid
// after that edge. Throughput is one item per cycle while the receiver does
// not stall, set by the single register stage between the command decode and
// the result register; a tick updates all cells at the edge that accepts it.
// When the receiver stalls, the result stays in the output register and the
// input is stalled only while that result is held and still stalled, so a
// new item can enter in the cycle the old result leaves.
// Reset clears all cells, pending events, flags, the tick count, the flow
// direction and the output register. The user must write the flow direction
// register via cfg_we_i and cfg_data_i while no item is in flight; unenforced.
module shifting_cell_register_fabric (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  port_index_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  superlane_i,
  input  logic [7:0]  stream_i,
  input  logic [7:0]  lane_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        cell_valid_o,
  output logic [7:0]  cell_data_o,
  output logic        collision_o,
  output logic        invalid_consume_o,
  output logic [31:0] tick_count_o
);

  scrf_pkg::dp_cmd_t dp_cmd;

  // The controller owns the handshake and tells the datapath when to act.
  scrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd)
  );

  // The datapath holds the fabric and the result register.
  scrf_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd_i),
    .port_index_i      (port_index_i),
    .column_i          (column_i),
    .superlane_i       (superlane_i),
    .stream_i          (stream_i),
    .lane_i            (lane_i),
    .data_i            (data_i),
    .accepted_o        (accepted_o),
    .cell_valid_o      (cell_valid_o),
    .cell_data_o       (cell_data_o),
    .collision_o       (collision_o),
    .invalid_consume_o (invalid_consume_o),
    .tick_count_o      (tick_count_o)
  );

endmodule

>>> src/scrf_checker.sv
// ----------------------------------------------------------------------------
// Shifting cell register fabric checker
// Port-level properties of the fabric, bound to the top level.
// ----------------------------------------------------------------------------
module scrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       accepted_o,
  input logic       cell_valid_o,
  input logic [7:0] cell_data_o
);

  // A held result stays offered until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The input is stalled only by a stalled, pending result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // A rejected item returns no cell contents.
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> !cell_valid_o && cell_data_o == 8'd0)
    else $error("rejected item carries cell contents");

  // A valid cell is only reported for an accepted item.
  a_valid_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_valid_o |-> accepted_o)
    else $error("cell valid on a rejected item");

endmodule

bind shifting_cell_register_fabric scrf_checker u_scrf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .accepted_o   (accepted_o),
  .cell_valid_o (cell_valid_o),
  .cell_data_o  (cell_data_o)
);
